[design/tste_pkg.sv]
`default_nettype none

package tste_pkg;

  // request codes carried on in_req_type
  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_ARM    = 2'd1,
    REQ_CANCEL = 2'd2
  } req_type_t;

  // timer tiers, nearest first
  typedef enum logic [1:0] {
    TIER_0 = 2'd0,
    TIER_1 = 2'd1,
    TIER_2 = 2'd2,
    TIER_3 = 2'd3
  } tier_t;

  // engine sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARM,
    ST_TINC,
    ST_TLIM,
    ST_SWEEP,
    ST_FLUSH
  } state_t;

  // one entry of the slot memory
  typedef struct packed {
    logic [63:0] expiry;
    tier_t       tier;
  } slot_ent_t;

  // tier spans in ticks
  localparam logic [63:0] SPAN_T0 = 64'd10;
  localparam logic [63:0] SPAN_T1 = 64'd100;
  localparam logic [63:0] SPAN_T2 = 64'd1000;

  // residue counters of the low tick word
  localparam int unsigned MOD10_W   = 4;
  localparam int unsigned MOD100_W  = 7;
  localparam int unsigned MOD1000_W = 10;
  localparam logic [MOD10_W-1:0]   MOD10_TOP   = 4'd9;
  localparam logic [MOD100_W-1:0]  MOD100_TOP  = 7'd99;
  localparam logic [MOD1000_W-1:0] MOD1000_TOP = 10'd999;

  // most timers fired on one tick
  localparam int unsigned MAX_FIRE = 16;
  localparam int unsigned FIRE_CW  = 5;

endpackage

`default_nettype wire

[design/tste_ram.sv]
`default_nettype none

module tste_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[design/tiered_software_timer_engine.sv]
`default_nettype none

// Tiered timer engine: SLOTS timer slots, each with a 64-bit expiry tick and
// a tier, kept in one single-port-read RAM. An arm request is accepted, then
// its tier is picked and written to the RAM; a cancel completes on accept. A
// tick is accepted, then the tick count is bumped, the promotion windows are
// prepared, and a sweep reads one slot per cycle from the RAM, unless a
// result stall holds it, passes it through the shared promote and expiry
// compares and writes it back; a last step flushes the final result. Each
// tick delivers one result per fired slot in ascending slot order, at most
// 16, with last set on the final one; a tick with nothing due delivers no
// result. A stall pauses the sweep only when a new fire meets a pending
// one. The input side takes a new request once the previous one is done,
// even while the last result still sits in the output register.
module tiered_software_timer_engine
  import tste_pkg::*;
#(
  parameter int unsigned SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [3:0]  in_slot,
  input  wire logic [63:0] in_expires,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_fired_slot,
  output logic             out_last,
  output logic [63:0]      out_tick_now
);

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned EW = $bits(slot_ent_t);

  state_t state_r, state_nxt;

  logic [63:0]          tick_r;
  logic [63:0]          lim100_r;
  logic [63:0]          lim1000_r;
  logic [MOD10_W-1:0]   mod10_r;
  logic [MOD100_W-1:0]  mod100_r;
  logic [MOD1000_W-1:0] mod1000_r;
  logic [SLOTS-1:0]     active_r;

  logic [SW-1:0]        req_addr_r;
  logic [63:0]          req_exp_r;

  logic [CW-1:0]        rd_idx_r;
  logic [SW-1:0]        ev_idx_r;
  logic                 ev_vld_r;
  logic [FIRE_CW-1:0]   fire_cnt_r;
  logic                 pend_vld_r;
  logic [SW-1:0]        pend_idx_r;

  logic                 out_valid_r;
  logic [3:0]           out_slot_r;
  logic                 out_last_r;
  logic [63:0]          out_tick_r;

  // request decode
  logic      in_acc;
  logic      slot_ok;
  logic [SW-1:0] in_addr;
  req_type_t in_req;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign slot_ok  = (32'(in_slot) < SLOTS);
  assign in_addr  = SW'(in_slot);
  assign in_req   = req_type_t'(in_req_type);

  // slot memory
  logic          ram_we;
  logic [SW-1:0] ram_waddr;
  slot_ent_t     ram_wdata;
  logic          ram_re;
  logic [SW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;
  slot_ent_t     ent;

  tste_ram #(
    .WIDTH (EW),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ent = slot_ent_t'(ram_rdata);

  // tier pick for an arm request
  logic [63:0] gap;
  tier_t       arm_tier;

  assign gap = req_exp_r - tick_r;

  always_comb begin
    if (gap < SPAN_T0) begin
      arm_tier = TIER_0;
    end else if (gap < SPAN_T1) begin
      arm_tier = TIER_1;
    end else if (gap < SPAN_T2) begin
      arm_tier = TIER_2;
    end else begin
      arm_tier = TIER_3;
    end
  end

  // promote and expiry check of the slot being swept
  logic  m10, m100, m1000;
  logic  le100, le1000, le_now;
  tier_t t_a, t_b, t_c;
  logic  fire;

  assign m10    = (mod10_r == '0);
  assign m100   = (mod100_r == '0);
  assign m1000  = (mod1000_r == '0);
  assign le100  = (ent.expiry <= lim100_r);
  assign le1000 = (ent.expiry <= lim1000_r);
  assign le_now = (ent.expiry <= tick_r);

  always_comb begin
    t_a = (m1000 && ent.tier == TIER_3 && le1000) ? TIER_1 : ent.tier;
    t_b = (m100 && t_a == TIER_2 && le1000) ? TIER_1 : t_a;
    t_c = (m10 && t_b == TIER_1 && le100) ? TIER_0 : t_b;
  end

  assign fire = ev_vld_r && active_r[ev_idx_r] && (t_c == TIER_0) && le_now &&
                (fire_cnt_r < FIRE_CW'(MAX_FIRE));

  // result register handshake
  logic out_free;
  logic sweep_done;
  logic adv;
  logic issue;

  assign out_free   = !out_valid_r || !out_stall;
  assign sweep_done = !ev_vld_r && (rd_idx_r == CW'(SLOTS));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_req)
            REQ_TICK: state_nxt = ST_TINC;
            REQ_ARM:  state_nxt = slot_ok ? ST_ARM : ST_IDLE;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ARM:   state_nxt = ST_IDLE;
      ST_TINC:  state_nxt = ST_TLIM;
      ST_TLIM:  state_nxt = ST_SWEEP;
      ST_SWEEP: begin
        if (sweep_done) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_vld_r || out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  logic          push;
  logic [SW-1:0] push_idx;
  logic          push_last;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ev_idx_r;
    ram_wdata = '{expiry: ent.expiry, tier: t_c};
    ram_re    = 1'b0;
    ram_raddr = SW'(rd_idx_r);
    push      = 1'b0;
    push_idx  = pend_idx_r;
    push_last = 1'b0;
    adv       = 1'b0;
    issue     = 1'b0;
    case (state_r)
      ST_ARM: begin
        ram_we    = 1'b1;
        ram_waddr = req_addr_r;
        ram_wdata = '{expiry: req_exp_r, tier: arm_tier};
      end
      ST_SWEEP: begin
        // hold the sweep while a new fire finds an earlier fire still waiting for the result register
        adv    = !(fire && pend_vld_r && !out_free);
        issue  = adv && (rd_idx_r < CW'(SLOTS));
        ram_re = issue;
        ram_we = adv && ev_vld_r;
        push   = adv && fire && pend_vld_r;
      end
      ST_FLUSH: begin
        push      = pend_vld_r && out_free;
        push_last = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // tick count and its residues
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r    <= '0;
      mod10_r   <= '0;
      mod100_r  <= '0;
      mod1000_r <= '0;
    end else if (state_r == ST_TINC) begin
      tick_r <= tick_r + 64'd1;
      if (tick_r[31:0] == '1) begin
        mod10_r   <= '0;
        mod100_r  <= '0;
        mod1000_r <= '0;
      end else begin
        mod10_r   <= (mod10_r == MOD10_TOP) ? '0 : mod10_r + 1'b1;
        mod100_r  <= (mod100_r == MOD100_TOP) ? '0 : mod100_r + 1'b1;
        mod1000_r <= (mod1000_r == MOD1000_TOP) ? '0 : mod1000_r + 1'b1;
      end
    end
  end

  // promotion windows
  always_ff @(posedge clk) begin
    if (state_r == ST_TLIM) begin
      lim100_r  <= tick_r + SPAN_T1;
      lim1000_r <= tick_r + SPAN_T2;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_addr_r <= in_addr;
      req_exp_r  <= in_expires;
    end
  end

  // armed flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else begin
      if (in_acc && in_req == REQ_CANCEL && slot_ok) begin
        active_r[in_addr] <= 1'b0;
      end
      if (state_r == ST_ARM) begin
        active_r[req_addr_r] <= 1'b1;
      end
      if (state_r == ST_SWEEP && adv && fire) begin
        active_r[ev_idx_r] <= 1'b0;
      end
    end
  end

  // sweep pointers and pending fire
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_vld_r   <= 1'b0;
      pend_vld_r <= 1'b0;
      rd_idx_r   <= '0;
      fire_cnt_r <= '0;
    end else begin
      case (state_r)
        ST_TLIM: begin
          ev_vld_r   <= 1'b0;
          pend_vld_r <= 1'b0;
          rd_idx_r   <= '0;
          fire_cnt_r <= '0;
        end
        ST_SWEEP: begin
          if (adv) begin
            ev_vld_r <= issue;
            ev_idx_r <= SW'(rd_idx_r);
            if (issue) begin
              rd_idx_r <= rd_idx_r + 1'b1;
            end
            if (fire) begin
              pend_vld_r <= 1'b1;
              pend_idx_r <= ev_idx_r;
              fire_cnt_r <= fire_cnt_r + 1'b1;
            end
          end
        end
        ST_FLUSH: begin
          if (push) begin
            pend_vld_r <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_slot_r <= 4'(push_idx);
      out_last_r <= push_last;
      out_tick_r <= tick_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_fired_slot = out_slot_r;
  assign out_last       = out_last_r;
  assign out_tick_now   = out_tick_r;

endmodule

`default_nettype wire
